>>> rtl/rzid_pkg.sv
// Package for the rolling z-score impulse detector.
// Widths, register indexes and the window statistics bundle; no dependencies.
package rzid_pkg;

  localparam int WIN_DEPTH = 64;
  localparam int WIN_AW    = 6;
  localparam int LEN_W     = 7;
  localparam int SMP_W     = 16;
  localparam int SUM_W     = 23;
  localparam int SQ_W      = 37;
  localparam int MAG_W     = 22;
  localparam int RAD_W     = 44;
  localparam int ROOT_W    = 22;
  localparam int DIV_W     = 32;
  localparam int DVS_W     = 22;
  localparam int ZMAG_W    = 15;
  localparam int CNT_W     = 32;

  localparam logic [ZMAG_W-1:0] Z_SAT = 15'h7FFF;

  localparam logic [1:0] REG_WLEN  = 2'd0;
  localparam logic [1:0] REG_MFILL = 2'd1;
  localparam logic [1:0] REG_ZLIM  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]        fill;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sqsum;
  } win_stats_t;

endpackage

>>> rtl/rolling_zscore_impulse_detector.sv
// Rolling-window z-score impulse detector, top level.
// Usage:
//   Input channel in_valid/in_stall/in_sample carries one signed Q8.8 sample
//   per transfer. Output channel out_valid/out_stall carries one result per
//   sample: z score, window mean and deviation, evaluated and impulse flags,
//   peak |z| and saturating impulse and sample counts.
//   APB port sets window_length (0x0, write clears window), min_fill (0x4)
//   and z_limit (0x8); pready is always high and reads return the registers.
// Timing:
//   One sample at a time: the result loads once the steps below are done and
//   the next transfer is taken in the cycle after it loads. Steps: window
//   read-modify-write, products, the bit-serial square root and the three
//   shared divider passes (z, mean, deviation).
//   Below the minimum fill the math is skipped and the result loads after
//   the window update.
// Reset and stall:
//   Synchronous active-low reset empties the window, zeroes peak and
//   counters and loads register defaults 32, 8, 768. Window memory is not
//   cleared; entries are read only after being written.
//   The result register holds while out_stall is high; a finished result
//   waits there while the next sample is already being taken.
// Depends on rzid_pkg, rzid_window, rzid_sqrt, rzid_div.
module rolling_zscore_impulse_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rzid_pkg::SMP_W-1:0]  in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rzid_pkg::SMP_W-1:0]  out_z_score,
  output logic signed [rzid_pkg::SMP_W-1:0]  out_window_mean,
  output logic [rzid_pkg::ZMAG_W-1:0]        out_window_std,
  output logic                               out_evaluated,
  output logic                               out_impulse,
  output logic [rzid_pkg::ZMAG_W-1:0]        out_peak_abs_z,
  output logic [rzid_pkg::CNT_W-1:0]         out_impulse_total,
  output logic [rzid_pkg::CNT_W-1:0]         out_sample_total,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rzid_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WIN  = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_SUB  = 9'b000001000,
    S_SQRT = 9'b000010000,
    S_DZ   = 9'b000100000,
    S_DM   = 9'b001000000,
    S_DS   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  wlen_r, mfill_r, wlen_wr;
  logic [ZMAG_W-1:0] zlim_r;
  logic              cfg_we, win_clear;
  logic [1:0]        cfg_idx;

  logic              win_start, win_done;
  win_stats_t        stats;

  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [RAD_W-1:0]  radicand;

  logic              div_start, div_done, div_rem_nz;
  logic [DIV_W-1:0]  div_dividend, div_quot;
  logic [DVS_W-1:0]  div_divisor;

  logic signed [SMP_W-1:0]   smp_r;
  logic                      eval_r;
  logic [RAD_W-1:0]          nq_r, ss_r;
  logic signed [SMP_W+7:0]   nx_r, num_r;
  logic [ROOT_W-1:0]         root_r;
  logic [DIV_W-1:0]          zq_r, mq_r, stdq_r;
  logic                      mnz_r;

  logic [MAG_W-1:0]          s_mag;
  logic [SMP_W+7:0]          num_mag;
  logic [ZMAG_W-1:0]         z_mag, std_val;
  logic signed [SMP_W-1:0]   z_val, mean_val;
  logic [SMP_W-1:0]          mq_adj;
  logic                      imp_val, out_free, out_load;

  logic                      out_valid_r, out_eval_r, out_imp_r;
  logic signed [SMP_W-1:0]   out_z_r, out_mean_r;
  logic [ZMAG_W-1:0]         out_std_r, peak_r;
  logic [CNT_W-1:0]          imp_cnt_r, smp_cnt_r;

  // Configuration
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[3:2];
  assign cfg_we    = psel && penable && pwrite;
  assign win_clear = cfg_we && (cfg_idx == REG_WLEN);

  always_comb begin
    wlen_wr = pwdata[LEN_W-1:0];
    if (wlen_wr == '0) begin
      wlen_wr = LEN_W'(1);
    end else if (wlen_wr > LEN_W'(WIN_DEPTH)) begin
      wlen_wr = LEN_W'(WIN_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= LEN_W'(32);
      mfill_r <= LEN_W'(8);
      zlim_r  <= ZMAG_W'(768);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WLEN:  wlen_r  <= wlen_wr;
        REG_MFILL: mfill_r <= pwdata[LEN_W-1:0];
        REG_ZLIM:  zlim_r  <= pwdata[ZMAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WLEN:  prdata = 32'(wlen_r);
      REG_MFILL: prdata = 32'(mfill_r);
      REG_ZLIM:  prdata = 32'(zlim_r);
      default:   prdata = '0;
    endcase
  end

  // Datapath units
  assign win_start = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);

  rzid_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (win_clear),
    .start  (win_start),
    .sample (in_sample),
    .wlen   (wlen_r),
    .done   (win_done),
    .stats  (stats)
  );

  assign radicand = (nq_r >= ss_r) ? (nq_r - ss_r) : '0;

  rzid_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SUB),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign s_mag   = stats.sum[SUM_W-1] ? MAG_W'(-stats.sum) : MAG_W'(stats.sum);
  assign num_mag = num_r[SMP_W+7] ? $unsigned(-num_r) : $unsigned(num_r);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_SQRT: begin
        div_start    = sqrt_done;
        div_dividend = {num_mag, 8'h00};
        div_divisor  = sqrt_root;
      end
      S_DZ: begin
        div_start    = div_done;
        div_dividend = DIV_W'(s_mag);
        div_divisor  = DVS_W'(stats.fill);
      end
      S_DM: begin
        div_start    = div_done;
        div_dividend = DIV_W'(root_r);
        div_divisor  = DVS_W'(stats.fill);
      end
      default: ;
    endcase
  end

  rzid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  // Sequencer
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_WIN;
      S_WIN:  if (win_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = (stats.fill >= mfill_r) ? S_SUB : S_FIN;
      S_SUB:  state_nxt = S_SQRT;
      S_SQRT: if (sqrt_done) state_nxt = S_DZ;
      S_DZ:   if (div_done) state_nxt = S_DM;
      S_DM:   if (div_done) state_nxt = S_DS;
      S_DS:   if (div_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: smp_r <= in_sample;
      S_MUL: begin
        eval_r <= (stats.fill >= mfill_r);
        nq_r   <= RAD_W'(stats.fill) * RAD_W'(stats.sqsum);
        ss_r   <= RAD_W'(s_mag) * RAD_W'(s_mag);
        nx_r   <= $signed({1'b0, stats.fill}) * smp_r;
      end
      S_SUB:  num_r <= nx_r - (SMP_W+8)'(stats.sum);
      S_SQRT: if (sqrt_done) root_r <= sqrt_root;
      S_DZ:   if (div_done) zq_r <= div_quot;
      S_DM: begin
        if (div_done) begin
          mq_r  <= div_quot;
          mnz_r <= div_rem_nz;
        end
      end
      S_DS:   if (div_done) stdq_r <= div_quot;
      default: ;
    endcase
  end

  // Result
  always_comb begin
    z_mag   = '0;
    std_val = '0;
    z_val   = '0;
    mean_val = '0;
    mq_adj  = SMP_W'(mq_r) + SMP_W'(mnz_r);
    if (eval_r) begin
      if (root_r != '0) begin
        z_mag = (zq_r > DIV_W'(Z_SAT)) ? Z_SAT : zq_r[ZMAG_W-1:0];
      end
      z_val    = num_r[SMP_W+7] ? -$signed({1'b0, z_mag}) : $signed({1'b0, z_mag});
      mean_val = stats.sum[SUM_W-1] ? $signed(-mq_adj) : $signed(SMP_W'(mq_r));
      std_val  = (stdq_r > DIV_W'(Z_SAT)) ? Z_SAT : stdq_r[ZMAG_W-1:0];
    end
    imp_val = eval_r && (z_mag > zlim_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      peak_r      <= '0;
      imp_cnt_r   <= '0;
      smp_cnt_r   <= '0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      if (z_mag > peak_r) begin
        peak_r <= z_mag;
      end
      if (imp_val && (imp_cnt_r != '1)) begin
        imp_cnt_r <= imp_cnt_r + CNT_W'(1);
      end
      if (smp_cnt_r != '1) begin
        smp_cnt_r <= smp_cnt_r + CNT_W'(1);
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_z_r    <= z_val;
      out_mean_r <= mean_val;
      out_std_r  <= std_val;
      out_eval_r <= eval_r;
      out_imp_r  <= imp_val;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_z_score       = out_z_r;
  assign out_window_mean   = out_mean_r;
  assign out_window_std    = out_std_r;
  assign out_evaluated     = out_eval_r;
  assign out_impulse       = out_imp_r;
  assign out_peak_abs_z    = peak_r;
  assign out_impulse_total = imp_cnt_r;
  assign out_sample_total  = smp_cnt_r;

`ifndef SYNTHESIS
  a_imp_needs_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_imp_r |-> out_eval_r)
    else $error("impulse without evaluation");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_eval_r |-> (out_z_r == '0) && (out_mean_r == '0) && (out_std_r == '0))
    else $error("unevaluated result not zero");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eval_r |->
      ((out_z_r[SMP_W-1] ? -out_z_r : out_z_r) <= $signed({1'b0, peak_r})))
    else $error("z above peak");

  a_sample_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (smp_cnt_r == $past(smp_cnt_r) + CNT_W'(1)) || (smp_cnt_r == '1))
    else $error("sample count not advanced");
`endif

endmodule

>>> rtl/rzid_window.sv
// Sample window: ring memory with fill count, running sum and sum of squares.
// Read-modify-write per sample: the old entry is read on start and overwritten while busy. Depends on rzid_pkg.
module rzid_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clear,
  input  logic                              start,
  input  logic signed [rzid_pkg::SMP_W-1:0] sample,
  input  logic [rzid_pkg::LEN_W-1:0]        wlen,
  output logic                              done,
  output rzid_pkg::win_stats_t              stats
);
  import rzid_pkg::*;

  logic signed [SMP_W-1:0]   mem [WIN_DEPTH];
  logic signed [SMP_W-1:0]   rd_q;
  logic signed [SMP_W-1:0]   smp_r;
  logic [WIN_AW-1:0]         slot_r, slot_nxt, addr_r, rd_addr;
  logic [LEN_W-1:0]          fill_r, fill_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt, old_ext;
  logic [SQ_W-1:0]           sq_r, sq_nxt, old_sq_ext;
  logic signed [2*SMP_W-1:0] old_sq, new_sq;
  logic                      busy_r, full_r;

  assign rd_addr = (LEN_W'(slot_r) >= wlen) ? '0 : slot_r;
  assign old_sq  = rd_q * rd_q;
  assign new_sq  = smp_r * smp_r;

  always_comb begin
    old_ext    = full_r ? SUM_W'(rd_q) : '0;
    old_sq_ext = full_r ? SQ_W'($unsigned(old_sq)) : '0;
    sum_nxt    = sum_r - old_ext + SUM_W'(smp_r);
    sq_nxt     = sq_r - old_sq_ext + SQ_W'($unsigned(new_sq));
    slot_nxt   = ((LEN_W'(addr_r) + LEN_W'(1)) >= wlen) ? '0 : addr_r + WIN_AW'(1);
    fill_nxt   = full_r ? fill_r : fill_r + LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      full_r <= 1'b0;
      addr_r <= '0;
      slot_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (clear) begin
      busy_r <= 1'b0;
      slot_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (busy_r) begin
      busy_r <= 1'b0;
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      sq_r   <= sq_nxt;
    end else if (start) begin
      busy_r <= 1'b1;
      addr_r <= rd_addr;
      full_r <= (fill_r >= wlen);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      smp_r <= sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (busy_r) begin
      mem[addr_r] <= smp_r;
    end
  end

  assign done        = busy_r;
  assign stats.fill  = fill_r;
  assign stats.sum   = sum_r;
  assign stats.sqsum = sq_r;

endmodule

>>> rtl/rzid_sqrt.sv
// Integer square root, restoring, two radicand bits per cycle.
// Depends on rzid_pkg.
module rzid_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rzid_pkg::RAD_W-1:0]   radicand,
  output logic                         done,
  output logic [rzid_pkg::ROOT_W-1:0]  root
);
  import rzid_pkg::*;

  localparam int CW = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+3:0] rem_t, trial;

  assign rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = (ROOT_W+4)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= (ROOT_W+2)'(rem_t - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= (ROOT_W+2)'(rem_t);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end else if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/rzid_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Shared for z, mean and deviation. Depends on rzid_pkg.
module rzid_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rzid_pkg::DIV_W-1:0]  dividend,
  input  logic [rzid_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [rzid_pkg::DIV_W-1:0]  quot,
  output logic                        rem_nz
);
  import rzid_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVS_W:0]   rem_t;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;

  assign rem_t = {rem_r, quo_r[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_r <= DVS_W'(rem_t - {1'b0, dvs_r});
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= DVS_W'(rem_t);
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end else if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end
  end

  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_nz = |rem_r;

endmodule
